>>> sv/line_follow_steering_control_top_assert.svh
// Assertion macros shared by the steering control block.
`ifndef LINE_FOLLOW_STEERING_CONTROL_TOP_ASSERT_SVH
`define LINE_FOLLOW_STEERING_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lfsc_pkg.sv
`default_nettype none

package lfsc_pkg;

  localparam int DRIVE_W = 16;
  localparam int TRIM_W  = 12;
  localparam int SPEED_W = 12;
  localparam int TURN_W  = 9;
  localparam int STEER_W = 26;
  localparam int DAMP_W  = 32;
  localparam int SUM_W   = 10;
  localparam int WORD_W  = 16;
  localparam int INDEX_W = 3;

  // Register indexes on the write port.
  localparam logic [INDEX_W-1:0] REG_KP_GAIN         = 3'd0;
  localparam logic [INDEX_W-1:0] REG_KD_GAIN         = 3'd1;
  localparam logic [INDEX_W-1:0] REG_RAMP_STEP       = 3'd2;
  localparam logic [INDEX_W-1:0] REG_SPEED_CAP       = 3'd3;
  localparam logic [INDEX_W-1:0] REG_LEFT_TRIM       = 3'd4;
  localparam logic [INDEX_W-1:0] REG_RIGHT_TRIM      = 3'd5;
  localparam logic [INDEX_W-1:0] REG_FINISH_WINDOW   = 3'd6;
  localparam logic [INDEX_W-1:0] REG_HALF_TURN_LIMIT = 3'd7;

  localparam logic [15:0]        KP_GAIN_RST         = 16'd2816;
  localparam logic signed [15:0] KD_GAIN_RST         = 16'sd0;
  localparam logic [7:0]         RAMP_STEP_RST       = 8'd2;
  localparam logic [11:0]        SPEED_CAP_RST       = 12'd1800;
  localparam logic signed [11:0] LEFT_TRIM_RST       = 12'sd310;
  localparam logic signed [11:0] RIGHT_TRIM_RST      = 12'sd380;
  localparam logic [7:0]         FINISH_WINDOW_RST   = 8'd20;
  localparam logic [7:0]         HALF_TURN_LIMIT_RST = 8'd170;

  // Sensor weights, left1..left4 then right4..right1.
  localparam logic signed [SUM_W-1:0] SENSOR_WEIGHT [8] = '{
    10'sd140, 10'sd120, 10'sd70, 10'sd22,
    -10'sd22, -10'sd70, -10'sd120, -10'sd140
  };

  localparam int CROSS_MIN = 3;
  localparam int CROSS_MAX = 6;

  typedef struct packed {
    logic [SPEED_W-1:0]        base;
    logic signed [STEER_W-1:0] steer;
    logic signed [DAMP_W-1:0]  damp;
  } drive_terms_t;

endpackage

`default_nettype wire

>>> sv/lfsc_in_if.sv
`default_nettype none

interface lfsc_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        line_bits;
  logic signed [8:0] yaw_angle;
  logic signed [15:0] yaw_rate;

  modport source (output valid, line_bits, yaw_angle, yaw_rate, input ready);
  modport sink   (input valid, line_bits, yaw_angle, yaw_rate, output ready);
endinterface

`default_nettype wire

>>> sv/lfsc_out_if.sv
`default_nettype none

interface lfsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;
  logic               brake;
  logic               finished;

  modport source (output valid, left_drive, right_drive, brake, finished, input ready);
  modport sink   (input valid, left_drive, right_drive, brake, finished, output ready);
endinterface

`default_nettype wire

>>> sv/line_follow_steering_control_top.sv
// Line follower steering control.
// sample (sink): one word per control tick with eight line sensor bits,
// yaw angle and yaw rate. result (source): one word per tick with the
// left and right motor commands, the brake strobe and the sticky
// finished flag. Registers are written through wr_en/wr_index/wr_data, only
// while no tick is in flight; the user must keep to this, the block does not enforce it.
// Each tick passes sensor decode into an input register, then a single pass
// of logic (base speed ramp, one 9x17 and one 16x16 multiply, saturation)
// into the result register, which presents the result word; one word is
// accepted every cycle while the receiver takes results. The multiply and
// add path into the result register sets the clock rate.
// If the receiver stalls, the result register holds its word and the input
// register takes one more word; after that sample.ready drops until the
// result is taken.
// Reset (synchronous, active high) empties both registers, loads the
// register defaults and clears base speed, turn value, half-lap and
// finished state.
`default_nettype none
`include "line_follow_steering_control_top_assert.svh"

module line_follow_steering_control_top
  import lfsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  lfsc_in_if.sink                  sample,
  lfsc_out_if.source               result,
  input  wire logic                wr_en,
  input  wire logic [INDEX_W-1:0]  wr_index,
  input  wire logic [WORD_W-1:0]   wr_data
);

  // Registers
  logic [15:0]        kp_gain;
  logic signed [15:0] kd_gain;
  logic [7:0]         ramp_step;
  logic [11:0]        speed_cap;
  logic signed [11:0] left_trim;
  logic signed [11:0] right_trim;
  logic [7:0]         finish_window;
  logic [7:0]         half_turn_limit;

  // Tick state
  logic [SPEED_W-1:0]       base_speed;
  logic signed [TURN_W-1:0] turn_value;
  logic                     half_lap_done;
  logic                     finish_flag;

  // Input register
  logic                     s1_valid;
  logic                     s1_many;
  logic                     s1_few;
  logic                     s1_none;
  logic signed [TURN_W-1:0] s1_quot;
  logic signed [8:0]        s1_yaw;
  logic signed [15:0]       s1_rate;

  logic s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain         <= KP_GAIN_RST;
      kd_gain         <= KD_GAIN_RST;
      ramp_step       <= RAMP_STEP_RST;
      speed_cap       <= SPEED_CAP_RST;
      left_trim       <= LEFT_TRIM_RST;
      right_trim      <= RIGHT_TRIM_RST;
      finish_window   <= FINISH_WINDOW_RST;
      half_turn_limit <= HALF_TURN_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_KP_GAIN:         kp_gain         <= wr_data;
        REG_KD_GAIN:         kd_gain         <= $signed(wr_data);
        REG_RAMP_STEP:       ramp_step       <= wr_data[7:0];
        REG_SPEED_CAP:       speed_cap       <= wr_data[11:0];
        REG_LEFT_TRIM:       left_trim       <= $signed(wr_data[11:0]);
        REG_RIGHT_TRIM:      right_trim      <= $signed(wr_data[11:0]);
        REG_FINISH_WINDOW:   finish_window   <= wr_data[7:0];
        REG_HALF_TURN_LIMIT: half_turn_limit <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // Sensor decode ahead of the input register
  logic [3:0]              cnt;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] half;

  always_comb begin
    cnt = '0;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      if (sample.line_bits[i]) begin
        cnt = cnt + 4'd1;
        sum = sum + SENSOR_WEIGHT[i];
      end
    end
    // Halve toward zero for two sensors.
    half = (sum + $signed({{(SUM_W-1){1'b0}}, sum[SUM_W-1]})) >>> 1;
  end

  assign s1_move      = s1_valid && (!result.valid || result.ready);
  assign sample.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_many <= cnt >= 4'(CROSS_MIN);
      s1_few  <= cnt < 4'(CROSS_MAX);
      s1_none <= cnt == 4'd0;
      s1_quot <= (cnt == 4'd1) ? TURN_W'(sum) : TURN_W'(half);
      s1_yaw  <= sample.yaw_angle;
      s1_rate <= sample.yaw_rate;
    end
  end

  // Tick logic
  logic [SPEED_W:0]          base_sum;
  logic [SPEED_W-1:0]        base_next;
  logic signed [TURN_W-1:0]  turn_next;
  logic signed [9:0]         yaw_w;
  logic signed [9:0]         fw_w;
  logic signed [9:0]         htl_w;
  logic                      finish_hit;
  logic                      half_lap_next;
  logic                      finish_flag_next;
  drive_terms_t              terms;
  logic signed [DRIVE_W-1:0] left_val;
  logic signed [DRIVE_W-1:0] right_val;

  always_comb begin
    base_sum  = {1'b0, base_speed} + (SPEED_W+1)'(ramp_step);
    base_next = (base_sum > {1'b0, speed_cap}) ? speed_cap : base_sum[SPEED_W-1:0];

    yaw_w = 10'(s1_yaw);
    fw_w  = $signed({2'b0, finish_window});
    htl_w = $signed({2'b0, half_turn_limit});

    finish_hit = s1_many && s1_few && half_lap_done && (yaw_w < fw_w) && (yaw_w > -fw_w);

    if (s1_many) begin
      turn_next = '0;
    end else if (s1_none) begin
      turn_next = turn_value;
    end else begin
      turn_next = s1_quot;
    end

    half_lap_next    = half_lap_done || (!finish_hit && ((yaw_w > htl_w) || (yaw_w < -htl_w)));
    finish_flag_next = finish_flag || finish_hit;

    terms.base  = base_next;
    terms.steer = STEER_W'(turn_next * $signed({1'b0, kp_gain}));
    terms.damp  = DAMP_W'(kd_gain * s1_rate);
  end

  lfsc_drive u_left (
    .terms     (terms),
    .steer_neg (1'b1),
    .trim      (left_trim),
    .drive     (left_val)
  );

  lfsc_drive u_right (
    .terms     (terms),
    .steer_neg (1'b0),
    .trim      (right_trim),
    .drive     (right_val)
  );

  // Advance state as the word leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed    <= '0;
      turn_value    <= '0;
      half_lap_done <= 1'b0;
      finish_flag   <= 1'b0;
    end else if (s1_move) begin
      base_speed    <= base_next;
      turn_value    <= turn_next;
      half_lap_done <= half_lap_next;
      finish_flag   <= finish_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_move) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.left_drive  <= finish_hit ? '0 : left_val;
      result.right_drive <= finish_hit ? '0 : right_val;
      result.brake       <= finish_hit;
      result.finished    <= finish_flag_next;
    end
  end

  `LFSC_ASSERT_NOW(a_brake_word, result.valid && result.brake, result.finished && (result.left_drive == 16'sd0) && (result.right_drive == 16'sd0), "brake word must carry finished and zero drives")
  `LFSC_ASSERT_NEXT(a_finish_sticky, finish_flag, finish_flag, "finished flag dropped")
  `LFSC_ASSERT_NEXT(a_speed_capped, s1_move, base_speed <= $past(speed_cap), "base speed above cap")
  `LFSC_ASSERT_NOW(a_stall_holds, s1_valid && result.valid && !result.ready, !sample.ready, "input taken with both registers full")

endmodule

`default_nettype wire

>>> sv/lfsc_drive.sv
`default_nettype none

module lfsc_drive
  import lfsc_pkg::*;
(
  input  wire drive_terms_t          terms,
  input  wire logic                  steer_neg,
  input  wire logic signed [TRIM_W-1:0] trim,
  output logic signed [DRIVE_W-1:0]  drive
);

  localparam int Q_W   = 34;
  localparam int V_W   = 26;
  localparam logic signed [V_W-1:0] SAT_HI = V_W'(32767);
  localparam logic signed [V_W-1:0] SAT_LO = -V_W'(32768);

  logic signed [Q_W-1:0] base_q;
  logic signed [Q_W-1:0] steer_q;
  logic signed [Q_W-1:0] q;
  logic signed [Q_W-1:0] q_shr;
  logic signed [V_W-1:0] scaled;
  logic signed [V_W-1:0] v;

  always_comb begin
    base_q  = $signed({{(Q_W-SPEED_W-8){1'b0}}, terms.base, 8'b0});
    steer_q = Q_W'(terms.steer);
    q       = steer_neg ? base_q - steer_q + Q_W'(terms.damp)
                        : base_q + steer_q + Q_W'(terms.damp);
    // Divide by 256 rounding toward zero.
    q_shr   = q >>> 8;
    scaled  = V_W'(q_shr);
    if (q[Q_W-1] && (|q[7:0])) begin
      scaled = scaled + V_W'(1);
    end
    v = scaled + V_W'(trim);
    if (v > SAT_HI) begin
      drive = DRIVE_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      drive = DRIVE_W'(SAT_LO);
    end else begin
      drive = DRIVE_W'(v);
    end
  end

endmodule

`default_nettype wire

>>> test/tb_line_follow_steering_control_top.sv
module tb_line_follow_steering_control_top;
  import lfsc_pkg::*;

  typedef struct {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               brake;
    logic               finished;
  } drive_word_t;

  // Tracks the steering state and registers, and queues the drive words due out.
  class steering_tracker;
    logic [15:0]        kp;
    logic signed [15:0] kd;
    logic [7:0]         ramp;
    logic [11:0]        cap;
    logic signed [11:0] left_trim;
    logic signed [11:0] right_trim;
    logic [7:0]         finish_win;
    logic [7:0]         half_limit;
    logic [11:0]        base_speed;
    logic signed [8:0]  turn;
    logic               half_lap;
    logic               finish_seen;
    drive_word_t        drive_due[$];
    int                 errors;

    function new();
      kp          = KP_GAIN_RST;
      kd          = KD_GAIN_RST;
      ramp        = RAMP_STEP_RST;
      cap         = SPEED_CAP_RST;
      left_trim   = LEFT_TRIM_RST;
      right_trim  = RIGHT_TRIM_RST;
      finish_win  = FINISH_WINDOW_RST;
      half_limit  = HALF_TURN_LIMIT_RST;
      base_speed  = '0;
      turn        = '0;
      half_lap    = 1'b0;
      finish_seen = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_KP_GAIN:         kp = data;
        REG_KD_GAIN:         kd = data;
        REG_RAMP_STEP:       ramp = data[7:0];
        REG_SPEED_CAP:       cap = data[11:0];
        REG_LEFT_TRIM:       left_trim = data[11:0];
        REG_RIGHT_TRIM:      right_trim = data[11:0];
        REG_FINISH_WINDOW:   finish_win = data[7:0];
        REG_HALF_TURN_LIMIT: half_limit = data[7:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clamp_drive(longint q, int trim);
      longint v;
      v = q / 256 + trim;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void take_tick(logic [7:0] bits, logic signed [8:0] yaw,
                            logic signed [15:0] rate);
      int          next_speed;
      int          wsum;
      int          nblack;
      int          yaw_deg;
      longint      base_q;
      longint      steer;
      longint      damp;
      drive_word_t w;
      next_speed = int'(base_speed) + int'(ramp);
      base_speed = (next_speed > int'(cap)) ? cap : next_speed[11:0];
      wsum = 0;
      nblack = 0;
      for (int i = 0; i < 8; i++) begin
        if (bits[i]) begin
          wsum += int'(SENSOR_WEIGHT[i]);
          nblack++;
        end
      end
      yaw_deg = int'(yaw);
      if (nblack >= CROSS_MIN) begin
        turn = '0;
        if (half_lap && yaw_deg < int'(finish_win) && yaw_deg > -int'(finish_win) &&
            nblack < CROSS_MAX) begin
          finish_seen = 1'b1;
          w.left_drive  = '0;
          w.right_drive = '0;
          w.brake       = 1'b1;
          w.finished    = 1'b1;
          drive_due.push_back(w);
          return;
        end
      end else if (nblack > 0) begin
        turn = 9'(wsum / nblack);
      end
      if (yaw_deg > int'(half_limit) || yaw_deg < -int'(half_limit)) half_lap = 1'b1;
      base_q = longint'(base_speed) * 256;
      steer  = longint'(turn) * longint'(kp);
      damp   = longint'(kd) * longint'(rate);
      w.left_drive  = clamp_drive(base_q - steer + damp, int'(left_trim));
      w.right_drive = clamp_drive(base_q + steer + damp, int'(right_trim));
      w.brake       = 1'b0;
      w.finished    = finish_seen;
      drive_due.push_back(w);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_drive(drive_word_t got);
      drive_word_t exp_w;
      if (drive_due.size() == 0) begin
        $display("%0t: result word with none expected, actual left %0d right %0d",
                 $time, got.left_drive, got.right_drive);
        errors++;
        return;
      end
      exp_w = drive_due.pop_front();
      compare_field("left_drive", int'(exp_w.left_drive), int'(got.left_drive));
      compare_field("right_drive", int'(exp_w.right_drive), int'(got.right_drive));
      compare_field("brake", int'(exp_w.brake), int'(got.brake));
      compare_field("finished", int'(exp_w.finished), int'(got.finished));
    endfunction

    function int pending();
      return drive_due.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [INDEX_W-1:0] wr_index;
  logic [WORD_W-1:0]  wr_data;
  bit                 idling_on;
  bit                 hold_results;

  lfsc_in_if  sample ();
  lfsc_out_if result ();

  steering_tracker tracker = new();

  line_follow_steering_control_top dut (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && sample.valid && sample.ready)
      tracker.take_tick(sample.line_bits, sample.yaw_angle, sample.yaw_rate);
  end

  always @(posedge clk) begin
    drive_word_t got;
    if (!rst && result.valid && result.ready) begin
      got.left_drive  = result.left_drive;
      got.right_drive = result.right_drive;
      got.brake       = result.brake;
      got.finished    = result.finished;
      tracker.check_drive(got);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        result.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_results = 1'b0;
        result.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result.ready <= 1'b1;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(logic [7:0] bits, logic signed [8:0] yaw, logic signed [15:0] rate);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid     <= 1'b1;
    sample.line_bits <= bits;
    sample.yaw_angle <= yaw;
    sample.yaw_rate  <= rate;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
  endtask

  // Sensors: none, one or two, three to five, or an arbitrary pattern; yaw mostly
  // near the window or the half-turn limit, so that laps complete, else arbitrary.
  task automatic send_random_tick();
    logic [7:0] bits;
    int         nwant;
    int         sel;
    int         y;
    int         r;
    bits = '0;
    sel = $urandom_range(0, 19);
    if (sel < 3) nwant = 0;
    else if (sel < 11) nwant = $urandom_range(1, 2);
    else if (sel < 16) nwant = $urandom_range(3, 5);
    else nwant = -1;
    if (nwant < 0) bits = 8'($urandom);
    else while ($countones(bits) < nwant) bits[$urandom_range(0, 7)] = 1'b1;
    sel = $urandom_range(0, 9);
    if (sel < 4) y = $urandom_range(0, int'(tracker.finish_win) + 1);
    else if (sel < 6) y = int'(tracker.half_limit) + int'($urandom_range(0, 2)) - 1;
    else y = int'($urandom_range(0, 360)) - 180;
    if (sel < 6 && $urandom_range(0, 1) == 1) y = -y;
    if (y > 180) y = 180;
    if (y < -180) y = -180;
    if ($urandom_range(0, 1) == 1) r = int'($urandom_range(0, 1000)) - 500;
    else r = $urandom;
    send_tick(bits, y[8:0], r[15:0]);
  endtask

  task automatic load_settings(int kp, int kd, int ramp, int cap, int ltrim, int rtrim,
                               int win, int lim);
    logic [INDEX_W-1:0] idx   [8];
    int                 value [8];
    idx   = '{REG_KP_GAIN, REG_KD_GAIN, REG_RAMP_STEP, REG_SPEED_CAP,
              REG_LEFT_TRIM, REG_RIGHT_TRIM, REG_FINISH_WINDOW, REG_HALF_TURN_LIMIT};
    value = '{kp, kd, ramp, cap, ltrim, rtrim, win, lim};
    for (int i = 0; i < 8; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[i];
      wr_data  <= value[i][WORD_W-1:0];
      tracker.write_reg(idx[i], value[i][WORD_W-1:0]);
      @(posedge clk);
    end
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and let every expected word come back before touching registers.
  task automatic drain();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) send_random_tick();
    drain();
  endtask

  initial begin
    rst              = 1'b1;
    wr_en            = 1'b0;
    wr_index         = '0;
    wr_data          = '0;
    sample.valid     = 1'b0;
    sample.line_bits = '0;
    sample.yaw_angle = '0;
    sample.yaw_rate  = '0;
    idling_on        = 1'b1;
    hold_results     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults: cross line before the half lap, then lap and finish cases.
    send_tick(8'h00, 9'sd0, 16'sd0);
    send_tick(8'h07, 9'sd0, 16'sd0);
    send_tick(8'h01, 9'sd180, 16'sd32767);
    send_tick(8'h80, -9'sd180, -16'sd32768);
    send_tick(8'h18, 9'sd5, 16'h5555);
    send_tick(8'h00, 9'sd0, 16'hAAAA);
    send_tick(8'h07, 9'sd0, 16'sd0);
    send_tick(8'hFF, 9'sd0, 16'sd100);
    send_tick(8'h3F, 9'sd1, -16'sd100);
    send_tick(8'h1F, 9'sd19, 16'sd7);
    send_tick(8'h0F, 9'sd20, 16'sd0);
    send_tick(8'h0F, -9'sd20, 16'sd0);
    send_tick(8'h0F, -9'sd19, 16'sd0);
    send_tick(8'h06, 9'sd170, 16'sd1);
    send_tick(8'h60, -9'sd171, -16'sd1);
    send_tick(8'h42, -9'sd1, 16'sd0);
    send_tick(8'h24, 9'sd0, 16'sd0);
    send_tick(8'h00, 9'sd90, 16'sd0);
    random_phase(150);

    // Upper extremes; fill the block while the receiver holds off.
    load_settings(65535, 32767, 255, 4095, -2048, 2047, 180, 0);
    idling_on    = 1'b0;
    hold_results = 1'b1;
    repeat (20) send_random_tick();
    idling_on = 1'b1;
    random_phase(330);

    // Lower extremes; the cap falls below the running base speed.
    load_settings(0, -32768, 0, 0, 2047, -2048, 0, 180);
    random_phase(300);

    repeat (2) begin
      load_settings($urandom_range(0, 65535), int'($urandom_range(0, 65535)) - 32768,
                    $urandom_range(0, 255), $urandom_range(0, 4095),
                    int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                    $urandom_range(0, 180), $urandom_range(0, 180));
      random_phase(400);
    end

    // Closing stretch with both sides running flat out.
    load_settings($urandom_range(0, 4096), int'($urandom_range(0, 1024)) - 512,
                  $urandom_range(1, 16), $urandom_range(500, 4095),
                  int'($urandom_range(0, 800)) - 400, int'($urandom_range(0, 800)) - 400,
                  $urandom_range(5, 40), $urandom_range(100, 175));
    idling_on = 1'b0;
    random_phase(400);

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
